>>> src/clock_digit_column_renderer_macros.svh
// assertion macros for the clock digit column renderer
// used by the top level; define ASSERT_OFF to drop every check
`ifndef CLOCK_DIGIT_COLUMN_RENDERER_MACROS_SVH
`define CLOCK_DIGIT_COLUMN_RENDERER_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold in every cycle out of reset
`define CDCR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition implies a consequence in the next cycle
`define CDCR_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`else

`define CDCR_ASSERT(lbl, clk, rst_n, prop, msg)
`define CDCR_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)

`endif

`endif

>>> src/cdcr_pkg.sv
// shared types, constants and font tables of the clock digit column renderer
// no dependencies; imported by clock_digit_column_renderer
`timescale 1ns / 1ps

package cdcr_pkg;

    // default number of chained 8x8 panels
    localparam int DEF_PANEL_COUNT = 4;

    // action codes of an input transaction
    typedef enum logic [2:0] {
        ACT_CLEAR   = 3'd0,
        ACT_TIME    = 3'd1,
        ACT_TOP_ROW = 3'd2,
        ACT_GLYPH   = 3'd3,
        ACT_PUSH    = 3'd4
    } t_action;

    // sequencer states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_WALK = 1'b1
    } t_state;

    // glyph picture kinds
    typedef enum logic [1:0] {
        GLY_LEFT  = 2'd0,
        GLY_MID   = 2'd1,
        GLY_RIGHT = 2'd2
    } t_glyph;

    // first column of each digit: hh, mm, ss
    localparam logic [5:0] DIGIT_START [6] = '{6'd2, 6'd6, 6'd12, 6'd16, 6'd22, 6'd26};
    localparam logic [5:0] COLON_A_COL = 6'd10;
    localparam logic [5:0] COLON_B_COL = 6'd20;
    localparam logic [7:0] COLON_BITS  = 8'h28;

    // 3x5 font, one 5-bit column per entry
    localparam logic [4:0] DIGIT_FONT [10][3] = '{
        '{5'h1F, 5'h11, 5'h1F}, '{5'h00, 5'h1F, 5'h00}, '{5'h1D, 5'h15, 5'h17},
        '{5'h11, 5'h15, 5'h1F}, '{5'h07, 5'h04, 5'h1F}, '{5'h17, 5'h15, 5'h1D},
        '{5'h1F, 5'h15, 5'h1D}, '{5'h01, 5'h01, 5'h1F}, '{5'h1F, 5'h15, 5'h1F},
        '{5'h17, 5'h15, 5'h1F}
    };

    // glyph pictures, stored row by row
    localparam logic [7:0] PIC_RIGHT [8] = '{8'h00, 8'h00, 8'h1e, 8'he1,
                                             8'h07, 8'he1, 8'h1e, 8'h00};
    localparam logic [7:0] PIC_MID   [8] = '{8'h00, 8'h00, 8'h00, 8'hff,
                                             8'h00, 8'hff, 8'h00, 8'h00};
    localparam logic [7:0] PIC_LEFT  [8] = '{8'h70, 8'h88, 8'h88, 8'h7f,
                                             8'h70, 8'h8f, 8'h88, 8'h70};

    // tens digit of a 7-bit value by reciprocal multiply, exact below 128
    function automatic logic [3:0] tens_of(input logic [6:0] v);
        logic [14:0] prod;
        prod = 15'(v) * 15'd205;
        return prod[14:11];
    endfunction

    // units digit of a 7-bit value
    function automatic logic [3:0] units_of(input logic [6:0] v);
        logic [6:0] rem;
        rem = v - 7'(tens_of(v) * 7'd10);
        return rem[3:0];
    endfunction

    // transposed glyph column x: row r lands in bit 7-r
    function automatic logic [7:0] glyph_col(input t_glyph kind, input logic [2:0] x);
        logic [7:0] bits;
        logic [7:0] row;
        bits = '0;
        for (int r = 0; r < 8; r++) begin
            unique case (kind)
                GLY_LEFT:  row = PIC_LEFT[r];
                GLY_MID:   row = PIC_MID[r];
                default:   row = PIC_RIGHT[r];
            endcase
            bits[7-r] = row[~x];
        end
        return bits;
    endfunction

endpackage

>>> src/clock_digit_column_renderer.sv
// top level of the clock digit column renderer: column framebuffer and sequencer
// depends on cdcr_pkg and clock_digit_column_renderer_macros.svh
`timescale 1ns / 1ps
//
// Usage
// - input channel (i_in_valid / o_in_stall) carries one action per transaction:
//   clear, draw time, draw top row, draw glyph or push
// - output channel (o_out_valid / i_out_stall) carries one column per transaction
//   during a push: column index, pixel byte (bit 0 = top row), last flag
// - config channel (i_cfg_valid / o_cfg_ready, always ready) writes the glyph enable
// - clear, unused actions, and a disabled glyph finish in the accepting cycle
// - draw time, draw top row, an enabled glyph and push walk all PANEL_COUNT*8 columns through
//   one read-modify-write path on the framebuffer memory, one column per cycle unless a
//   push is held by a receiver stall; the input stays stalled until the walk ends
// - push: each column passes the read stage and the output register, then one per cycle
//   while the receiver takes them; a receiver stall holds the output register and
//   pauses the column walk, nothing is lost
// - reset (synchronous, active low) empties the framebuffer through per-column
//   valid bits, sets the glyph enable and drops any pending output
//
`include "clock_digit_column_renderer_macros.svh"

module clock_digit_column_renderer
    import cdcr_pkg::*;
#(
    parameter int PANEL_COUNT = DEF_PANEL_COUNT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input transactions
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_action,
    input  logic [6:0]  i_hours,
    input  logic [6:0]  i_minutes,
    input  logic [6:0]  i_seconds,
    input  logic [31:0] i_centiseconds,
    // output transactions
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [5:0]  o_column,
    output logic [7:0]  o_column_bits,
    output logic        o_last,
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data
);

    localparam int TOTAL_COLS = PANEL_COUNT * 8;
    localparam int ADDR_W     = $clog2(TOTAL_COLS);
    localparam int CNT_W      = ADDR_W + 1;
    localparam logic [CNT_W-1:0]  COL_END   = CNT_W'(TOTAL_COLS);
    localparam logic [ADDR_W-1:0] COL_LAST  = ADDR_W'(TOTAL_COLS - 1);
    localparam logic [6:0]        COLS_7    = 7'(TOTAL_COLS);
    localparam bit                HAS_GLYPH = (PANEL_COUNT >= 4);
    localparam logic [2:0] PANEL_LAST = 3'(PANEL_COUNT - 1);
    localparam logic [2:0] PANEL_PREV = 3'((PANEL_COUNT >= 2) ? PANEL_COUNT - 2 : 0);

    // state
    t_state              r_state, n_state;
    t_action             r_act;
    logic [CNT_W-1:0]    r_col;
    logic [3:0]          r_digit [6];
    logic [31:0]         r_cs;
    logic                r_glyph_en;
    logic [TOTAL_COLS-1:0] r_fill;
    logic [7:0]          r_frame_mem [TOTAL_COLS];

    // read stage
    logic                r_rd_vld;
    logic [ADDR_W-1:0]   r_rd_col;
    logic [7:0]          r_rd_data;
    logic                r_rd_fill;

    // output register
    logic                r_out_valid;
    logic [5:0]          r_out_col;
    logic [7:0]          r_out_bits;
    logic                r_out_last;

    // control
    logic                in_accept;
    logic                start_walk;
    logic                out_free;
    logic                consume;
    logic                rd_en;
    logic                wr_en;
    logic                out_load;
    logic [7:0]          old_bits;
    logic [7:0]          new_bits;
    logic [5:0]          col_ext;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // actions that walk the columns
    always_comb begin
        start_walk = 1'b0;
        unique case (i_action)
            ACT_TIME, ACT_TOP_ROW, ACT_PUSH: start_walk = 1'b1;
            ACT_GLYPH:                       start_walk = r_glyph_en && HAS_GLYPH;
            default:                         start_walk = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept && start_walk) n_state = ST_WALK;
            end
            ST_WALK: begin
                if (r_col == COL_END && (!r_rd_vld || consume)) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
        out_free   = !r_out_valid || !i_out_stall;
        consume    = r_rd_vld && ((r_act != ACT_PUSH) || out_free);
        rd_en      = (r_state == ST_WALK) && (r_col != COL_END) && (!r_rd_vld || consume);
        wr_en      = consume && (r_act != ACT_PUSH);
        out_load   = consume && (r_act == ACT_PUSH);
    end

    // column rewrite for the draw actions
    always_comb begin
        logic [5:0] s;
        logic [5:0] off;
        old_bits = r_rd_fill ? r_rd_data : 8'h00;
        col_ext  = 6'(r_rd_col);
        new_bits = old_bits;
        s        = '0;
        off      = '0;
        unique case (r_act)
            ACT_TIME: begin
                for (int i = 0; i < 6; i++) begin
                    s   = DIGIT_START[i];
                    off = col_ext - s;
                    if (col_ext >= s && col_ext < s + 6'd3 && (7'(s) + 7'd3 <= COLS_7)
                        && r_digit[i] <= 4'd9) begin
                        new_bits = {1'b0, DIGIT_FONT[r_digit[i]][off[1:0]], 1'b0, old_bits[0]};
                    end
                end
                if (col_ext == COLON_A_COL || col_ext == COLON_B_COL) begin
                    new_bits = COLON_BITS | {7'd0, old_bits[0]};
                end
            end
            ACT_TOP_ROW: begin
                new_bits = {old_bits[7:1], (col_ext < 6'd32) ? r_cs[~col_ext[4:0]] : 1'b0};
            end
            ACT_GLYPH: begin
                priority if (col_ext[5:3] == 3'd0)       new_bits = glyph_col(GLY_LEFT, col_ext[2:0]);
                else if (col_ext[5:3] == 3'd1)         new_bits = glyph_col(GLY_MID, col_ext[2:0]);
                else if (col_ext[5:3] == PANEL_PREV)   new_bits = glyph_col(GLY_MID, col_ext[2:0]);
                else if (col_ext[5:3] == PANEL_LAST)   new_bits = glyph_col(GLY_RIGHT, col_ext[2:0]);
                else                                   new_bits = old_bits;
            end
            default: new_bits = old_bits;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_act       <= ACT_CLEAR;
            r_col       <= '0;
            r_glyph_en  <= 1'b1;
            r_fill      <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) r_glyph_en <= i_cfg_data;
            if (in_accept) begin
                r_act <= t_action'(i_action);
                r_col <= '0;
            end else if (rd_en) begin
                r_col <= r_col + CNT_W'(1);
            end
            // clear drops every column at once
            if (in_accept && i_action == ACT_CLEAR) r_fill <= '0;
            else if (wr_en) r_fill[r_rd_col] <= 1'b1;
            if (rd_en) r_rd_vld <= 1'b1;
            else if (consume) r_rd_vld <= 1'b0;
            if (out_load) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    // operand capture
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_digit[0] <= tens_of(i_hours);
            r_digit[1] <= units_of(i_hours);
            r_digit[2] <= tens_of(i_minutes);
            r_digit[3] <= units_of(i_minutes);
            r_digit[4] <= tens_of(i_seconds);
            r_digit[5] <= units_of(i_seconds);
            r_cs       <= i_centiseconds;
        end
    end

    // framebuffer memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) r_frame_mem[r_rd_col] <= new_bits;
        if (rd_en) begin
            r_rd_data <= r_frame_mem[r_col[ADDR_W-1:0]];
            r_rd_fill <= r_fill[r_col[ADDR_W-1:0]];
            r_rd_col  <= r_col[ADDR_W-1:0];
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_col  <= 6'(r_rd_col);
            r_out_bits <= old_bits;
            r_out_last <= (r_rd_col == COL_LAST);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_column      = r_out_col;
    assign o_column_bits = r_out_bits;
    assign o_last        = r_out_last;

    // checks
    `CDCR_ASSERT(a_idle_no_read, i_clk, i_rst_n, (r_state == ST_IDLE) -> !r_rd_vld, "read pending while idle")
    `CDCR_ASSERT(a_write_in_walk, i_clk, i_rst_n, wr_en -> (r_state == ST_WALK), "framebuffer write outside a walk")
    `CDCR_ASSERT(a_col_bound, i_clk, i_rst_n, r_col <= COL_END, "column counter past the end")
    `CDCR_ASSERT(a_out_col_bound, i_clk, i_rst_n, o_out_valid -> (7'(o_column) < COLS_7), "column index out of range")
    `CDCR_ASSERT_NEXT(a_last_ends_walk, i_clk, i_rst_n, out_load && (r_rd_col == COL_LAST), r_state == ST_IDLE, "walk continues after last column")

endmodule

>>> bench/clock_digit_column_renderer_test.sv
// self-checking bench for clock_digit_column_renderer: a directed action list, then a random mix
// keeps its own framebuffer model and compares every pushed column; needs cdcr_pkg and the top level
`timescale 1ns / 1ps

module clock_digit_column_renderer_test
    import cdcr_pkg::*;
();

    localparam int PANELS        = 4;
    localparam int COLUMNS       = PANELS * 8;
    localparam int RANDOM_ITEMS  = 235;
    localparam int SETTLE_CYCLES = COLUMNS + 8;
    localparam longint TIMEOUT_NS = 64'd20_000_000;

    // action codes the block ignores
    localparam logic [2:0] ACT_SPARE_A = 3'd5;
    localparam logic [2:0] ACT_SPARE_B = 3'd6;
    localparam logic [2:0] ACT_SPARE_C = 3'd7;

    // digit and colon placement of hh:mm:ss
    localparam int DIGIT_COL [6] = '{2, 6, 12, 16, 22, 26};
    localparam int COLON_COL_A = 10;
    localparam int COLON_COL_B = 20;
    localparam logic [7:0] COLON_PIXELS = 8'h28;

    // 3x5 font, three 5-bit columns per digit
    localparam logic [0:9][0:2][4:0] FONT = {
        5'h1F, 5'h11, 5'h1F,  5'h00, 5'h1F, 5'h00,  5'h1D, 5'h15, 5'h17,
        5'h11, 5'h15, 5'h1F,  5'h07, 5'h04, 5'h1F,  5'h17, 5'h15, 5'h1D,
        5'h1F, 5'h15, 5'h1D,  5'h01, 5'h01, 5'h1F,  5'h1F, 5'h15, 5'h1F,
        5'h17, 5'h15, 5'h1F
    };

    // glyph pictures, top row first
    localparam logic [0:7][7:0] GLYPH_RIGHT = {8'h00, 8'h00, 8'h1e, 8'he1,
                                               8'h07, 8'he1, 8'h1e, 8'h00};
    localparam logic [0:7][7:0] GLYPH_MID   = {8'h00, 8'h00, 8'h00, 8'hff,
                                               8'h00, 8'hff, 8'h00, 8'h00};
    localparam logic [0:7][7:0] GLYPH_LEFT  = {8'h70, 8'h88, 8'h88, 8'h7f,
                                               8'h70, 8'h8f, 8'h88, 8'h70};

    typedef struct packed {
        logic [5:0] column;
        logic [7:0] pixels;
        logic       is_last;
    } column_beat_t;

    // one input transaction; typed rows carry the byte every pushed column must show
    typedef struct packed {
        logic [2:0]  action;
        logic [6:0]  hours;
        logic [6:0]  minutes;
        logic [6:0]  seconds;
        logic [31:0] centis;
        logic        set_enable;
        logic        enable_value;
        logic        typed;
        logic [7:0]  typed_pixels;
    } stim_row_t;

    typedef enum int {
        STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC, STALL_BLOCKS
    } stall_mode_t;

    localparam stim_row_t DIRECTED_ROWS [25] = '{
        // dark frame straight after reset
        '{ACT_PUSH,    7'd0,   7'd0,   7'd0,   32'h0000_0000, 1'b0, 1'b0, 1'b1, 8'h00},
        // full top row, then only the top row lit
        '{ACT_TOP_ROW, 7'd0,   7'd0,   7'd0,   32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 8'h00},
        '{ACT_PUSH,    7'd0,   7'd0,   7'd0,   32'h0000_0000, 1'b0, 1'b0, 1'b1, 8'h01},
        '{ACT_CLEAR,   7'd0,   7'd0,   7'd0,   32'h0000_0000, 1'b0, 1'b0, 1'b0, 8'h00},
        '{ACT_PUSH,    7'd0,   7'd0,   7'd0,   32'h0000_0000, 1'b0, 1'b0, 1'b1, 8'h00},
        '{ACT_TIME,    7'd12,  7'd34,  7'd56,  32'h0000_0000, 1'b0, 1'b0, 1'b0, 8'h00},
        '{ACT_TOP_ROW, 7'd0,   7'd0,   7'd0,   32'h8000_0001, 1'b0, 1'b0, 1'b0, 8'h00},
        '{ACT_PUSH,    7'd0,   7'd0,   7'd0,   32'h0000_0000, 1'b0, 1'b0, 1'b0, 8'h00},
        '{ACT_TIME,    7'd99,  7'd99,  7'd99,  32'h0000_0000, 1'b0, 1'b0, 1'b0, 8'h00},
        '{ACT_PUSH,    7'd0,   7'd0,   7'd0,   32'h0000_0000, 1'b0, 1'b0, 1'b0, 8'h00},
        // values of 100 and more: tens digit left alone
        '{ACT_TIME,    7'd127, 7'd100, 7'd109, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 8'h00},
        '{ACT_PUSH,    7'd0,   7'd0,   7'd0,   32'h0000_0000, 1'b0, 1'b0, 1'b0, 8'h00},
        '{ACT_TIME,    7'd0,   7'd0,   7'd0,   32'h0000_0000, 1'b0, 1'b0, 1'b0, 8'h00},
        '{ACT_TOP_ROW, 7'd0,   7'd0,   7'd0,   32'h5A5A_A5A5, 1'b0, 1'b0, 1'b0, 8'h00},
        '{ACT_GLYPH,   7'd0,   7'd0,   7'd0,   32'h0000_0000, 1'b0, 1'b0, 1'b0, 8'h00},
        '{ACT_PUSH,    7'd0,   7'd0,   7'd0,   32'h0000_0000, 1'b0, 1'b0, 1'b0, 8'h00},
        // time over the glyph keeps the top row
        '{ACT_TIME,    7'd23,  7'd59,  7'd59,  32'h0000_0000, 1'b0, 1'b0, 1'b0, 8'h00},
        '{ACT_PUSH,    7'd0,   7'd0,   7'd0,   32'h0000_0000, 1'b0, 1'b0, 1'b0, 8'h00},
        // unused actions change nothing
        '{ACT_SPARE_A, 7'd127, 7'd127, 7'd127, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 8'h00},
        '{ACT_SPARE_B, 7'd85,  7'd42,  7'd64,  32'h0000_0000, 1'b0, 1'b0, 1'b0, 8'h00},
        '{ACT_SPARE_C, 7'd0,   7'd0,   7'd0,   32'h1234_5678, 1'b0, 1'b0, 1'b0, 8'h00},
        '{ACT_PUSH,    7'd0,   7'd0,   7'd0,   32'h0000_0000, 1'b0, 1'b0, 1'b0, 8'h00},
        '{ACT_CLEAR,   7'd0,   7'd0,   7'd0,   32'h0000_0000, 1'b0, 1'b0, 1'b0, 8'h00},
        // glyph disabled draws nothing
        '{ACT_GLYPH,   7'd0,   7'd0,   7'd0,   32'h0000_0000, 1'b1, 1'b0, 1'b0, 8'h00},
        '{ACT_PUSH,    7'd0,   7'd0,   7'd0,   32'h0000_0000, 1'b0, 1'b0, 1'b1, 8'h00}
    };

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_stall;
    logic [2:0]  i_action       = 3'd0;
    logic [6:0]  i_hours        = 7'd0;
    logic [6:0]  i_minutes      = 7'd0;
    logic [6:0]  i_seconds      = 7'd0;
    logic [31:0] i_centiseconds = 32'd0;
    logic        o_out_valid;
    logic        i_out_stall    = 1'b0;
    logic [5:0]  o_column;
    logic [7:0]  o_column_bits;
    logic        o_last;
    logic        i_cfg_valid    = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data     = 1'b0;

    // framebuffer model and the columns still owed by the block
    logic [7:0]   frame_model [COLUMNS];
    logic         glyph_enable_model = 1'b1;
    column_beat_t pending_columns [$];

    int mismatch_count  = 0;
    int items_sent      = 0;
    int pushes_sent     = 0;
    int columns_checked = 0;
    int enable_writes   = 0;
    int burst_left      = 0;

    stall_mode_t stall_mode      = STALL_NONE;
    int          stall_mode_left = 0;
    int          stall_run_left  = 0;
    logic        stall_run_on    = 1'b0;

    clock_digit_column_renderer #(
        .PANEL_COUNT(PANELS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_hours        (i_hours),
        .i_minutes      (i_minutes),
        .i_seconds      (i_seconds),
        .i_centiseconds (i_centiseconds),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_column       (o_column),
        .o_column_bits  (o_column_bits),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        foreach (frame_model[c]) frame_model[c] = 8'h00;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // digit columns keep the top-row bit; digits above 9 and digits that do not fit are skipped
    function automatic void draw_digit(input int digit, input int first_col);
        if (digit > 9 || first_col + 3 > COLUMNS) return;
        for (int i = 0; i < 3; i++)
            frame_model[first_col + i] = {1'b0, FONT[digit][i], 1'b0,
                                          frame_model[first_col + i][0]};
    endfunction

    function automatic void draw_colon(input int col);
        if (col < COLUMNS) frame_model[col] = COLON_PIXELS | {7'd0, frame_model[col][0]};
    endfunction

    // transpose a picture: row r lands in bit 7-r of column x
    function automatic void paint_panel(input int panel, input logic [0:7][7:0] rows);
        logic [7:0] pixels;
        for (int x = 0; x < 8; x++) begin
            pixels = 8'h00;
            for (int r = 0; r < 8; r++) pixels[7 - r] = rows[r][7 - x];
            if (panel * 8 + x < COLUMNS) frame_model[panel * 8 + x] = pixels;
        end
    endfunction

    // apply one accepted action to the model; a push queues every column
    function automatic void render_action(input stim_row_t row);
        int hr;
        int mn;
        int sc;
        column_beat_t beat;
        hr = int'(row.hours);
        mn = int'(row.minutes);
        sc = int'(row.seconds);
        case (row.action)
            ACT_CLEAR: begin
                foreach (frame_model[c]) frame_model[c] = 8'h00;
            end
            ACT_TIME: begin
                draw_digit(hr / 10, DIGIT_COL[0]);
                draw_digit(hr % 10, DIGIT_COL[1]);
                draw_colon(COLON_COL_A);
                draw_digit(mn / 10, DIGIT_COL[2]);
                draw_digit(mn % 10, DIGIT_COL[3]);
                draw_colon(COLON_COL_B);
                draw_digit(sc / 10, DIGIT_COL[4]);
                draw_digit(sc % 10, DIGIT_COL[5]);
            end
            ACT_TOP_ROW: begin
                // columns past bit 31 get a dark top pixel
                for (int c = 0; c < COLUMNS; c++)
                    frame_model[c][0] = (c < 32) ? row.centis[31 - c] : 1'b0;
            end
            ACT_GLYPH: begin
                if (glyph_enable_model && PANELS >= 4) begin
                    paint_panel(PANELS - 1, GLYPH_RIGHT);
                    paint_panel(PANELS - 2, GLYPH_MID);
                    paint_panel(1, GLYPH_MID);
                    paint_panel(0, GLYPH_LEFT);
                end
            end
            ACT_PUSH: begin
                for (int c = 0; c < COLUMNS; c++) begin
                    beat.column  = 6'(c);
                    beat.pixels  = frame_model[c];
                    beat.is_last = (c == COLUMNS - 1);
                    pending_columns.push_back(beat);
                end
            end
            default: ;
        endcase
    endfunction

    // drive one transaction and hold it until the block takes it
    task automatic send_action(input stim_row_t row);
        column_beat_t beat;
        i_in_valid     <= 1'b1;
        i_action       <= row.action;
        i_hours        <= row.hours;
        i_minutes      <= row.minutes;
        i_seconds      <= row.seconds;
        i_centiseconds <= row.centis;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        if (row.action == ACT_PUSH) pushes_sent++;
        if (row.typed) begin
            for (int c = 0; c < COLUMNS; c++) begin
                beat.column  = 6'(c);
                beat.pixels  = row.typed_pixels;
                beat.is_last = (c == COLUMNS - 1);
                pending_columns.push_back(beat);
            end
        end else begin
            render_action(row);
        end
    endtask

    // bursts of back-to-back transactions separated by idle gaps with junk payload
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(3) == 0) ? $urandom_range(20, 45) : $urandom_range(1, 8);
            i_in_valid     <= 1'b0;
            i_action       <= 3'($urandom);
            i_hours        <= 7'($urandom);
            i_centiseconds <= $urandom;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(15, 40)
                                                  : $urandom_range(1, 6);
        end
        burst_left--;
    endtask

    // stop sending until every owed column is back and the block has settled
    task automatic drain_columns();
        i_in_valid <= 1'b0;
        while (pending_columns.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_glyph_enable(input logic value);
        drain_columns();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        glyph_enable_model = value;
        enable_writes++;
    endtask

    // mostly plausible clock times and pushes, some out-of-range times and unused actions
    function automatic stim_row_t random_row();
        stim_row_t row;
        int pick;
        row         = '0;
        row.hours   = 7'($urandom_range(127));
        row.minutes = 7'($urandom_range(127));
        row.seconds = 7'($urandom_range(127));
        row.centis  = $urandom;
        pick        = $urandom_range(99);
        if (pick < 30) begin
            row.action = ACT_PUSH;
        end else if (pick < 52) begin
            row.action  = ACT_TIME;
            row.hours   = 7'($urandom_range(23));
            row.minutes = 7'($urandom_range(59));
            row.seconds = 7'($urandom_range(59));
        end else if (pick < 60) begin
            row.action = ACT_TIME;
        end else if (pick < 74) begin
            row.action = ACT_TOP_ROW;
        end else if (pick < 84) begin
            row.action = ACT_GLYPH;
        end else if (pick < 92) begin
            row.action = ACT_CLEAR;
        end else begin
            row.action = 3'($urandom_range(ACT_SPARE_A, ACT_SPARE_C));
        end
        return row;
    endfunction

    // output side: check each column transaction, then pick the next stall value
    always @(posedge i_clk) begin : column_check
        column_beat_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_columns.size() == 0) begin
                report_mismatch($sformatf("column %0d arrived with nothing pending", o_column));
            end else begin
                want = pending_columns.pop_front();
                columns_checked++;
                if (o_column !== want.column)
                    report_mismatch($sformatf("column index %0d, want %0d",
                                              o_column, want.column));
                if (o_column_bits !== want.pixels)
                    report_mismatch($sformatf("column %0d pixels %02h, want %02h",
                                              want.column, o_column_bits, want.pixels));
                if (o_last !== want.is_last)
                    report_mismatch($sformatf("column %0d last %b, want %b",
                                              want.column, o_last, want.is_last));
            end
        end
        if (stall_mode_left == 0) begin
            stall_mode      = stall_mode_t'($urandom_range(4));
            stall_mode_left = $urandom_range(40, 300);
        end
        stall_mode_left--;
        case (stall_mode)
            STALL_NONE:     i_out_stall <= 1'b0;
            STALL_LIGHT:    i_out_stall <= ($urandom_range(3) == 0);
            STALL_HEAVY:    i_out_stall <= ($urandom_range(9) < 7);
            STALL_PERIODIC: i_out_stall <= (stall_mode_left % 4 == 0);
            default: begin
                if (stall_run_left == 0) begin
                    stall_run_left = $urandom_range(4, 20);
                    stall_run_on   = !stall_run_on;
                end
                stall_run_left--;
                i_out_stall <= stall_run_on;
            end
        endcase
    end

    // main sequence
    initial begin
        stim_row_t row;
        int phase;
        int phase_left;
        int random_done;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_glyph_enable(1'b1);

        // directed list
        foreach (DIRECTED_ROWS[i]) begin
            if (DIRECTED_ROWS[i].set_enable)
                write_glyph_enable(DIRECTED_ROWS[i].enable_value);
            else
                pace_sender();
            send_action(DIRECTED_ROWS[i]);
        end

        // random phases, the glyph enable is written anew between them
        random_done = 0;
        phase       = 0;
        while (random_done < RANDOM_ITEMS) begin
            if (phase == 0)
                write_glyph_enable(1'b1);
            else if (phase == 1)
                write_glyph_enable(1'b0);
            else
                write_glyph_enable(1'($urandom_range(1)));
            phase_left = $urandom_range(20, 60);
            while (phase_left > 0 && random_done < RANDOM_ITEMS) begin
                pace_sender();
                if ($urandom_range(39) == 0) drain_columns();
                row = random_row();
                send_action(row);
                if (row.action <= ACT_PUSH) begin
                    random_done++;
                    phase_left--;
                end
            end
            phase++;
        end

        drain_columns();
        if (pending_columns.size() != 0)
            report_mismatch($sformatf("%0d columns never arrived", pending_columns.size()));
        $display("covered %0d actions in %0d random phases, %0d enable writes",
                 items_sent, phase, enable_writes);
        $display("%0d pushes, %0d columns compared, %0d mismatches",
                 pushes_sent, columns_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("clock_digit_column_renderer regression: pass");
        else
            $display("clock_digit_column_renderer regression: fail");
        $finish;
    end

    // run limit
    initial begin
        #(TIMEOUT_NS);
        $display("run limit reached with %0d columns pending", pending_columns.size());
        $display("clock_digit_column_renderer regression: fail");
        $finish;
    end

endmodule

>>> sim.f
+incdir+src
src/cdcr_pkg.sv
src/clock_digit_column_renderer.sv
bench/clock_digit_column_renderer_test.sv
